/* sv/local_minimum_3x3_detect_unit_assert.svh */
// ----------------------------------------------------------------------------
// Local minimum 3x3 detect unit - assertion macros
// Concurrent checks for simulation. They collapse to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef LOCAL_MINIMUM_3X3_DETECT_UNIT_ASSERT_SVH
`define LOCAL_MINIMUM_3X3_DETECT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define LMD_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error(msg);
// same-cycle implication
`define LMD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LMD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LMD_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define LMD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define LMD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

/* sv/lmd_pkg.sv */
// ----------------------------------------------------------------------------
// Local minimum 3x3 detect - package
// Sizes, register map, request codes and word types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmd_pkg;

  localparam int MAX_COLS     = 128;
  localparam int MAX_ROWS     = 4096;
  localparam int SAMPLE_WIDTH = 16;

  localparam int COL_W   = $clog2(MAX_COLS);   // column index
  localparam int ROW_W   = $clog2(MAX_ROWS);   // row index
  localparam int NCOLS_W = COL_W + 1;          // column count, holds MAX_COLS
  localparam int NROWS_W = ROW_W + 1;          // row count, holds MAX_ROWS and drain

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // register indexes (byte address / 4)
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  localparam logic [NROWS_W-1:0] NUM_ROWS_RESET = NROWS_W'(64);
  localparam logic [NCOLS_W-1:0] NUM_COLS_RESET = NCOLS_W'(64);

  // request codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic                           req_type;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } pixel_word_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic        [ROW_W-1:0]        row;
    logic        [COL_W-1:0]        col;
    logic                           is_min;
    logic                           frame_end;
  } result_word_t;

endpackage

/* sv/lmd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data (old data on a
// read of the address written in the same cycle).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/local_minimum_3x3_detect_unit.sv */
// ----------------------------------------------------------------------------
// Local minimum 3x3 detect unit
// Flags every pixel of a raster frame that has no strictly smaller in-frame
// 8-neighbour, using two line stores and a 3x3 window.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake                    | word
//   ---------+-----------+------------------------------+---------------------
//   pixel    | in        | pixel_valid / pixel_ready    | lmd_pkg::pixel_word_t
//   result   | out       | result_valid / result_ready  | lmd_pkg::result_word_t
//   config   | in        | psel/penable/pwrite, pready  | 32-bit APB registers
//
// Throughput is one pixel word per cycle while results are taken. A word
// completing a window is taken into the compare stage registers; the accept
// edge also registers the line store read, and the window compare then feeds
// the result register. Reset clears counters, configuration registers and
// handshake state only; line stores and window hold garbage until written,
// and no clearing pass runs. When the result register is full and not taken,
// the compare stage holds one more word and then drops pixel_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "local_minimum_3x3_detect_unit_assert.svh"

module local_minimum_3x3_detect_unit (
  input  logic                                clk,
  input  logic                                rst,
  // pixel stream
  input  logic                                pixel_valid,
  output logic                                pixel_ready,
  input  lmd_pkg::pixel_word_t                pixel,
  // results
  output logic                                result_valid,
  input  logic                                result_ready,
  output lmd_pkg::result_word_t               result,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lmd_pkg::ADDR_W-1:0]          paddr,
  input  logic [lmd_pkg::DATA_W-1:0]          pwdata,
  output logic [lmd_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  localparam int SW = lmd_pkg::SAMPLE_WIDTH;
  localparam int CW = lmd_pkg::COL_W;
  localparam int RW = lmd_pkg::ROW_W;
  localparam int NCW = lmd_pkg::NCOLS_W;
  localparam int NRW = lmd_pkg::NROWS_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [NRW-1:0] num_rows;
  logic [NCW-1:0] num_cols;
  logic           cfg_wr;
  logic           reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= lmd_pkg::NUM_ROWS_RESET;
      num_cols <= lmd_pkg::NUM_COLS_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        lmd_pkg::REG_NUM_ROWS: num_rows <= pwdata[NRW-1:0];
        lmd_pkg::REG_NUM_COLS: num_cols <= pwdata[NCW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      lmd_pkg::REG_NUM_ROWS: prdata = lmd_pkg::DATA_W'(num_rows);
      lmd_pkg::REG_NUM_COLS: prdata = lmd_pkg::DATA_W'(num_cols);
      default: prdata = '0;
    endcase
  end

  // Clamp the frame size into the supported range; zero acts as one.
  logic [NRW-1:0] rows_m;
  logic [NCW-1:0] cols_n;

  always_comb begin
    if (num_rows == '0) begin
      rows_m = NRW'(1);
    end else if (num_rows > NRW'(lmd_pkg::MAX_ROWS)) begin
      rows_m = NRW'(lmd_pkg::MAX_ROWS);
    end else begin
      rows_m = num_rows;
    end
    if (num_cols == '0) begin
      cols_n = NCW'(1);
    end else if (num_cols > NCW'(lmd_pkg::MAX_COLS)) begin
      cols_n = NCW'(lmd_pkg::MAX_COLS);
    end else begin
      cols_n = num_cols;
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: position counters, line store addressing
  // ---------------------------------------------------------------------------
  // in_row runs up to two past the last row while the flush ticks drain the frame.
  logic [NRW-1:0] in_row, in_row_next;
  logic [CW-1:0]  in_col, in_col_next;
  logic [RW-1:0]  out_row, out_row_next;
  logic [CW-1:0]  out_col, out_col_next;

  logic           b_valid;
  logic           b_adv;
  logic           take;        // word handshake this cycle
  logic           flush;
  logic           ignore;      // flush while pixels are still expected
  logic           active;      // word that moves the window
  logic           emit_a;
  logic           last_a;
  logic [NCW-1:0] in_col_inc;
  logic [NCW-1:0] out_col_inc;
  logic [NRW-1:0] out_row_inc;
  logic [SW-1:0]  x_a;

  assign pixel_ready = !b_valid || b_adv;
  assign take        = pixel_valid && pixel_ready;
  assign flush       = (pixel.req_type == lmd_pkg::REQ_FLUSH);
  assign ignore      = flush && (in_row < rows_m);
  assign active      = take && !ignore;
  assign x_a         = flush ? '0 : pixel.sample;

  assign emit_a = (in_row >= NRW'(2)) || ((in_row == NRW'(1)) && (in_col != '0));

  assign in_col_inc  = {1'b0, in_col} + NCW'(1);
  assign out_col_inc = {1'b0, out_col} + NCW'(1);
  assign out_row_inc = {1'b0, out_row} + NRW'(1);
  assign last_a      = (out_row_inc == rows_m) && (out_col_inc == cols_n);

  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    if (cfg_wr) begin
      // a register write aborts the frame
      in_row_next  = '0;
      in_col_next  = '0;
      out_row_next = '0;
      out_col_next = '0;
    end else if (active) begin
      if (in_col_inc >= cols_n) begin
        in_col_next = '0;
        in_row_next = in_row + NRW'(1);
      end else begin
        in_col_next = in_col_inc[CW-1:0];
      end
      if (emit_a) begin
        if (last_a) begin
          // frame done: start over at (0,0)
          in_row_next  = '0;
          in_col_next  = '0;
          out_row_next = '0;
          out_col_next = '0;
        end else if (out_col_inc >= cols_n) begin
          out_col_next = '0;
          out_row_next = out_row_inc[RW-1:0];
        end else begin
          out_col_next = out_col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores
  // ---------------------------------------------------------------------------
  // line_above is read and written at the accept stage (old data comes back).
  // line_two_above gets the tap of line_above when the compare stage advances;
  // a read of the address being written in the same cycle takes the bypass
  // instead of the stale RAM data.
  logic [CW-1:0]  b_addr;
  logic [SW-1:0]  tap1_raw;
  logic [SW-1:0]  tap2_raw;
  logic [SW-1:0]  prev_tap1;
  logic           b_byp;

  lmd_ram #(
    .WIDTH (SW),
    .DEPTH (lmd_pkg::MAX_COLS)
  ) u_line_above (
    .clk   (clk),
    .we    (active),
    .waddr (in_col),
    .wdata (x_a),
    .re    (active),
    .raddr (in_col),
    .rdata (tap1_raw)
  );

  lmd_ram #(
    .WIDTH (SW),
    .DEPTH (lmd_pkg::MAX_COLS)
  ) u_line_two_above (
    .clk   (clk),
    .we    (b_adv),
    .waddr (b_addr),
    .wdata (tap1_raw),
    .re    (active),
    .raddr (in_col),
    .rdata (tap2_raw)
  );

  // ---------------------------------------------------------------------------
  // Compare stage registers
  // ---------------------------------------------------------------------------
  logic           b_emit;
  logic           b_last;
  logic           b_top;
  logic           b_bottom;
  logic           b_left;
  logic           b_right;
  logic [RW-1:0]  b_row;
  logic [CW-1:0]  b_col;
  logic [SW-1:0]  b_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (active) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  // payload of the compare stage, no reset needed
  always_ff @(posedge clk) begin
    if (active) begin
      b_addr   <= in_col;
      b_x      <= x_a;
      b_byp    <= b_valid && (b_addr == in_col);
      b_emit   <= emit_a;
      b_last   <= last_a;
      b_row    <= out_row;
      b_col    <= out_col;
      b_top    <= (out_row == '0);
      b_bottom <= (out_row_inc >= rows_m);
      b_left   <= (out_col == '0);
      b_right  <= (out_col_inc >= cols_n);
    end
    if (b_adv) begin
      prev_tap1 <= tap1_raw;
    end
  end

  logic signed [SW-1:0] tap1;
  logic signed [SW-1:0] tap2;

  assign tap1 = tap1_raw;
  assign tap2 = b_byp ? prev_tap1 : tap2_raw;

  // Advance unless a result is due and the result register cannot take it.
  assign b_adv = b_valid && (!b_emit || !result_valid || result_ready);

  // ---------------------------------------------------------------------------
  // 3x3 window: [row][col], row 0 is two lines up, col 2 is the newest
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] win [3][3];

  always_ff @(posedge clk) begin
    if (b_adv) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= tap2;
      win[1][2] <= tap1;
      win[2][2] <= b_x;
    end
  end

  // Judge the center pixel against the window as it stands after this shift.
  logic signed [SW-1:0] centre;
  logic                 is_min_b;

  assign centre = win[1][2];

  always_comb begin
    is_min_b = 1'b1;
    if (!b_top) begin
      if (!b_left  && (win[0][1] < centre)) is_min_b = 1'b0;
      if (             win[0][2] < centre ) is_min_b = 1'b0;
      if (!b_right && (tap2      < centre)) is_min_b = 1'b0;
    end
    if (!b_left  && (win[1][1] < centre)) is_min_b = 1'b0;
    if (!b_right && (tap1      < centre)) is_min_b = 1'b0;
    if (!b_bottom) begin
      if (!b_left  && (win[2][1] < centre)) is_min_b = 1'b0;
      if (             win[2][2] < centre ) is_min_b = 1'b0;
      if (!b_right && ($signed(b_x) < centre)) is_min_b = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic load_res;

  assign load_res = b_adv && b_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_res) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      result.value     <= centre;
      result.row       <= b_row;
      result.col       <= b_col;
      result.is_min    <= is_min_b;
      result.frame_end <= b_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  logic [NCW-1:0] in_col_ext;
  logic [NRW-1:0] out_row_ext;
  logic           ign_take;

  assign in_col_ext  = {1'b0, in_col};
  assign out_row_ext = {1'b0, out_row};
  assign ign_take    = take && ignore;

  `LMD_ASSERT_IMP(a_stall_blocks_input, clk, rst, b_valid && !b_adv, !pixel_ready, "ready in stall")
  `LMD_ASSERT(a_in_col_range, clk, rst, in_col_ext < cols_n, "arrival column beyond width")
  `LMD_ASSERT(a_out_row_range, clk, rst, out_row_ext < rows_m, "judged row beyond height")
  `LMD_ASSERT_NXT(a_ignored_flush_drops, clk, rst, ign_take, !b_valid, "ignored flush staged")

endmodule
